// ===== hw/rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 rgba box blur
// widths, line buffer size, output queue size, divider constants
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int MAX_SIDE   = 1024;
	localparam int COL_AW     = $clog2(MAX_SIDE);
	localparam int SIDE_W     = 11;
	localparam int POS_W      = 10;
	localparam int PIX_W      = 32;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 4;
	localparam int SUM_W      = 12;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	// output queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = OUTQ_AW + 1;

	// reciprocal constants, exact for the sum ranges met here
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP3      = 21846;
	localparam int RECIP9      = 7282;

	localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);
	localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);

	// register indexes
	localparam logic REG_IMAGE_SIDE = 1'b0;

	typedef enum logic [1:0] {
		DIV4,
		DIV6,
		DIV9
	} div_sel_t;

	// line buffer write request: {older, newer} pair per column
	typedef struct packed {
		logic                 en;
		logic [COL_AW-1:0]    addr;
		logic [2*PIX_W-1:0]   data;
	} lb_wr_t;

	// one finished result
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} res_t;

endpackage

// ===== hw/rtl/bb3_linebuf.sv =====
// ----------------------------------------------------------------------------
// bb3_linebuf: two line buffers held as one column-wide memory
// each word holds the column's pixel of row r-2 (high) and row r-1 (low)
// ----------------------------------------------------------------------------
module bb3_linebuf
	import bb3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [COL_AW-1:0]    rd_addr,
	input  lb_wr_t               wr,
	output logic [2*PIX_W-1:0]   rd_data
);

	logic [2*PIX_W-1:0] lb_mem_q [MAX_SIDE];
	logic [2*PIX_W-1:0] rd_q;
	logic [2*PIX_W-1:0] byp_q;
	logic               hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			lb_mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q  <= lb_mem_q[rd_addr];
			byp_q <= wr.data;
		end
	end

	// read and write of the same column in one cycle: forward the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (rd_en) begin
			hit_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	assign rd_data = hit_q ? byp_q : rd_q;

endmodule

// ===== hw/rtl/bb3_outq.sv =====
// ----------------------------------------------------------------------------
// bb3_outq: short result queue in front of the output channel
// absorbs the extra results released at row ends
// ----------------------------------------------------------------------------
module bb3_outq
	import bb3_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  res_t               push_data,
	input  logic               out_stall,
	output logic               out_valid,
	output res_t               head,
	output logic [OUTQ_CW-1:0] count
);

	res_t               q_mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wr_ptr_q;
	logic [OUTQ_AW-1:0] rd_ptr_q;
	logic [OUTQ_CW-1:0] cnt_q;
	logic               pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = q_mem_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUTQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + OUTQ_CW'(1);
				2'b01:   cnt_q <= cnt_q - OUTQ_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && (cnt_q == OUTQ_CW'(OUTQ_DEPTH)) |-> pop)
		else $error("result queue overflow");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == OUTQ_CW'(OUTQ_DEPTH)) || (cnt_q == '0) ||
		((wr_ptr_q - rd_ptr_q) == cnt_q[OUTQ_AW-1:0]))
		else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/box_blur_3x3_rgba_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgba_core: streaming 3x3 box blur over a square rgba image
// per-channel floor mean over the clipped 3x3 neighbourhood, results
// released as soon as their last input pixel has arrived
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  -----------------------------------------
//  input     in_valid / in_stall    pixel_in, frame_start
//  output    out_valid / out_stall  blurred_pixel, out_row, out_col,
//                                   last_of_run
//  config    apb psel/penable       image_side at byte address 0
//
//  one request a cycle while in_stall is low; a request makes 0, 1, 2 or 4
//  results, one a cycle while the queue has room, so past row 0 and column 0
//  a pixel in the last row or column holds the input until its results are issued
//  input is registered in stages 1, 2 and 3 before the output queue
//  reset clears position, window, pipeline valids, queue and sets side 1024
//  the line buffers are not cleared; out_stall backs up through a 4-deep
//  queue into the summing unit and then into in_stall
//
module box_blur_3x3_rgba_core
	import bb3_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  pixel_in,
	input  logic              frame_start,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  blurred_pixel,
	output logic [POS_W-1:0]  out_row,
	output logic [POS_W-1:0]  out_col,
	output logic              last_of_run
);

	// ------------------------------------------------------------------
	// configuration register
	// ------------------------------------------------------------------
	logic [SIDE_W-1:0] side_q;
	logic [SIDE_W-1:0] side_eff;
	logic [SIDE_W-1:0] side_m1;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (cfg_wr && (paddr[APB_AW-1] == REG_IMAGE_SIDE)) begin
			side_q <= pwdata[SIDE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[APB_AW-1])
			REG_IMAGE_SIDE: prdata = APB_DW'(side_q);
			default:        prdata = '0;
		endcase
	end

	// out-of-range sides are clamped to the supported range
	always_comb begin
		side_eff = side_q;
		if (side_q < SIDE_MIN) begin
			side_eff = SIDE_MIN;
		end else if (side_q > SIDE_RESET) begin
			side_eff = SIDE_RESET;
		end
	end

	assign side_m1 = side_eff - SIDE_W'(1);

	// ------------------------------------------------------------------
	// handshake control between stages
	// ------------------------------------------------------------------
	logic in_acc;
	logic s1_v_q;
	logic s1_adv;
	logic s2_free;

	assign s1_adv   = s1_v_q && s2_free;
	assign in_stall = s1_v_q && !s2_free;
	assign in_acc   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// position of the incoming pixel
	// ------------------------------------------------------------------
	logic [POS_W-1:0]  row_q, col_q;
	logic [SIDE_W-1:0] r_a, c_a, r_inc, c_inc;
	logic [POS_W-1:0]  cur_r, cur_c, nxt_r, nxt_c;

	always_comb begin
		r_a = frame_start ? '0 : SIDE_W'(row_q);
		c_a = frame_start ? '0 : SIDE_W'(col_q);
		// column beyond the side (side shrunk) moves to the next row
		if (c_a >= side_eff) begin
			c_a = '0;
			r_a = r_a + SIDE_W'(1);
		end
		if (r_a >= side_eff) begin
			r_a = '0;
		end
		cur_r = r_a[POS_W-1:0];
		cur_c = c_a[POS_W-1:0];
		r_inc = SIDE_W'(cur_r) + SIDE_W'(1);
		c_inc = SIDE_W'(cur_c) + SIDE_W'(1);
		if (c_inc >= side_eff) begin
			nxt_c = '0;
			nxt_r = (r_inc >= side_eff) ? '0 : r_inc[POS_W-1:0];
		end else begin
			nxt_c = c_inc[POS_W-1:0];
			nxt_r = cur_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			row_q <= nxt_r;
			col_q <= nxt_c;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: registered pixel and line buffer read
	// ------------------------------------------------------------------
	logic [PIX_W-1:0]   pix_s1;
	logic [POS_W-1:0]   r_s1, c_s1;
	logic [2*PIX_W-1:0] lb_rd;
	logic [PIX_W-1:0]   older_s1, newer_s1;
	lb_wr_t             lb_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_acc) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= pixel_in;
			r_s1   <= cur_r;
			c_s1   <= cur_c;
		end
	end

	assign older_s1 = lb_rd[2*PIX_W-1:PIX_W];
	assign newer_s1 = lb_rd[PIX_W-1:0];

	// column rotates: row r-1 becomes r-2, the new pixel becomes r-1
	always_comb begin
		lb_wr.en   = s1_adv;
		lb_wr.addr = c_s1[COL_AW-1:0];
		lb_wr.data = {newer_s1, pix_s1};
	end

	bb3_linebuf u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (cur_c[COL_AW-1:0]),
		.wr      (lb_wr),
		.rd_data (lb_rd)
	);

	// number of result rows and columns this pixel releases
	logic [1:0] ny_s1, nx_s1;

	always_comb begin
		if (SIDE_W'(r_s1) == side_m1) begin
			ny_s1 = 2'd2;
		end else if (r_s1 != '0) begin
			ny_s1 = 2'd1;
		end else begin
			ny_s1 = 2'd0;
		end
		if (SIDE_W'(c_s1) == side_m1) begin
			nx_s1 = 2'd2;
		end else if (c_s1 != '0) begin
			nx_s1 = 2'd1;
		end else begin
			nx_s1 = 2'd0;
		end
	end

	// ------------------------------------------------------------------
	// 3x3 window, [row][col], rows r-2..r, cols c-2..c
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (s1_adv) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= older_s1;
			win_q[1][2] <= newer_s1;
			win_q[2][2] <= pix_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: one result a cycle, while the queue has room, from the window
	// ------------------------------------------------------------------
	logic             s2_v_q;
	logic [POS_W-1:0] r_s2, c_s2;
	logic             nx2_s2;
	logic [2:0]       cnt_s2;
	logic [1:0]       k_q;
	logic             s3_v_q;
	logic [OUTQ_CW-1:0] q_count;
	logic             room, issue, k_last, s2_done;

	assign room    = (q_count + OUTQ_CW'(s3_v_q)) < OUTQ_CW'(OUTQ_DEPTH);
	assign issue   = s2_v_q && (cnt_s2 != '0) && room;
	assign k_last  = ({1'b0, k_q} + 3'd1) == cnt_s2;
	assign s2_done = s2_v_q && ((cnt_s2 == '0) || (issue && k_last));
	assign s2_free = !s2_v_q || s2_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
			k_q    <= '0;
		end else begin
			if (s1_adv) begin
				s2_v_q <= 1'b1;
			end else if (s2_done) begin
				s2_v_q <= 1'b0;
			end
			if (s2_done) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			r_s2   <= r_s1;
			c_s2   <= c_s1;
			nx2_s2 <= nx_s1[1];
			cnt_s2 <= 3'(ny_s1) * 3'(nx_s1);
		end
	end

	// results go in raster order: rows r-1 then r, columns c-1 then c
	logic             sel_a, sel_b;
	logic [POS_W-1:0] y_s2, x_s2;
	logic [2:0]       row_en, col_en;
	logic             row3, col3;
	logic [SUM_W-1:0] sum_s2 [NUM_CH];
	div_sel_t         div_s2;

	always_comb begin
		sel_b  = nx2_s2 ? k_q[0] : 1'b0;
		sel_a  = nx2_s2 ? k_q[1] : k_q[0];
		y_s2   = sel_a ? r_s2 : r_s2 - POS_W'(1);
		x_s2   = sel_b ? c_s2 : c_s2 - POS_W'(1);
		// output on the newest row or column has no neighbour beyond it
		row_en = sel_a ? 3'b110 : {2'b11, (y_s2 != '0)};
		col_en = sel_b ? 3'b110 : {2'b11, (x_s2 != '0)};
		row3   = &row_en;
		col3   = &col_en;
		if (row3 && col3) begin
			div_s2 = DIV9;
		end else if (!row3 && !col3) begin
			div_s2 = DIV4;
		end else begin
			div_s2 = DIV6;
		end
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum_s2[ch] = '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (row_en[i] && col_en[j]) begin
						sum_s2[ch] = sum_s2[ch] +
							SUM_W'(win_q[i][j][PIX_W-1-CH_W*ch -: CH_W]);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 3: divide by 4, 6 or 9 and push into the queue
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] sum_s3 [NUM_CH];
	div_sel_t         div_s3;
	logic [POS_W-1:0] y_s3, x_s3;
	logic             last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_q <= 1'b0;
		end else begin
			s3_v_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sum_s3  <= sum_s2;
			div_s3  <= div_s2;
			y_s3    <= y_s2;
			x_s3    <= x_s2;
			last_s3 <= k_last;
		end
	end

	localparam int PROD_W = SUM_W + RECIP_SHIFT;

	logic [PROD_W-1:0] mul_in [NUM_CH];
	logic [PROD_W-1:0] mul_k;
	logic [PROD_W-1:0] prod [NUM_CH];
	logic [PIX_W-1:0]  mean_s3;
	res_t              push_res;

	// floor(x/6) = floor(floor(x/2)/3); reciprocals are exact below 2296
	always_comb begin
		mul_k = (div_s3 == DIV6) ? PROD_W'(RECIP3) : PROD_W'(RECIP9);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			mul_in[ch] = (div_s3 == DIV6) ? PROD_W'(sum_s3[ch] >> 1) :
				PROD_W'(sum_s3[ch]);
			prod[ch]   = mul_in[ch] * mul_k;
			case (div_s3) inside
				DIV4:    mean_s3[PIX_W-1-CH_W*ch -: CH_W] = sum_s3[ch][CH_W+1:2];
				DIV6,
				DIV9:    mean_s3[PIX_W-1-CH_W*ch -: CH_W] =
					prod[ch][RECIP_SHIFT +: CH_W];
				default: mean_s3[PIX_W-1-CH_W*ch -: CH_W] = sum_s3[ch][CH_W+1:2];
			endcase
		end
		push_res.pixel = mean_s3;
		push_res.row   = y_s3;
		push_res.col   = x_s3;
		push_res.last  = last_s3;
	end

	// ------------------------------------------------------------------
	// output queue
	// ------------------------------------------------------------------
	res_t head;

	bb3_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s3_v_q),
		.push_data (push_res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.count     (q_count)
	);

	assign blurred_pixel = head.pixel;
	assign out_row       = head.row;
	assign out_col       = head.col;
	assign last_of_run   = head.last;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_pos_in_side: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (SIDE_W'(col_q) < $past(side_eff)) &&
			(SIDE_W'(row_q) < $past(side_eff)))
		else $error("next position outside the image");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q && (cnt_s2 != '0) |-> ({1'b0, k_q} < cnt_s2))
		else $error("result index past the item's result count");

	a_issue_pos: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (r_s2 != '0) && (c_s2 != '0))
		else $error("result released before its neighbourhood arrived");

endmodule
